### sv/assert_macros.svh
// Assertion helpers shared by the RTL. Each macro expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KLEB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("kleb assertion failed");
`define KLEB_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("kleb forbidden condition");
`else
`define KLEB_ASSERT(lbl, prop)
`define KLEB_NEVER(lbl, cond)
`endif
`endif

### sv/kleb_pkg.sv
package kleb_pkg;

  localparam int BUFFER_DEPTH = 256;
  // cells per first-level read reduction group
  localparam int GROUP_SIZE   = 16;

  localparam logic [1:0] MODE_KEY   = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [7:0] KEY_HOME  = 8'h5B;
  localparam logic [7:0] KEY_END   = 8'h5D;
  localparam logic [7:0] KEY_LEFT  = 8'h7B;
  localparam logic [7:0] KEY_RIGHT = 8'h7D;
  localparam logic [7:0] KEY_INS   = 8'h2D;
  localparam logic [7:0] KEY_BKSP  = 8'h3D;
  localparam logic [7:0] KEY_NL    = 8'h0A;

  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_INS  = 2'd1;
  localparam logic [1:0] CELL_OVR  = 2'd2;
  localparam logic [1:0] CELL_DEL  = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] key;
    logic [7:0] read_index;
  } in_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic [8:0] text_length;
    logic [8:0] cursor_pos;
    logic       insert_on;
    logic       overflow;
  } out_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
  } cell_ctl_t;

endpackage

### sv/kleb_cell.sv
module kleb_cell #(
  parameter int Idx  = 0,
  parameter int PosW = 9
) (
  input  logic               clk_i,
  input  kleb_pkg::cell_ctl_t ctl_i,
  input  logic [PosW-1:0]    pos_i,
  input  logic [7:0]         left_i,
  input  logic [7:0]         right_i,
  input  logic [7:0]         rd_idx_i,
  output logic [7:0]         char_o,
  output logic [7:0]         rd_o
);

  localparam logic [PosW-1:0] MyPos  = PosW'(Idx);
  localparam bit              Readable = (Idx < 256);

  logic [7:0] char_q, char_d;

  always_comb begin
    char_d = char_q;
    case (ctl_i.op)
      kleb_pkg::CELL_INS: begin
        if (MyPos > pos_i) begin
          char_d = left_i;
        end else if (MyPos == pos_i) begin
          char_d = ctl_i.ch;
        end
      end
      kleb_pkg::CELL_OVR: begin
        if (MyPos == pos_i) begin
          char_d = ctl_i.ch;
        end
      end
      kleb_pkg::CELL_DEL: begin
        // pos is the slot before the cursor; everything from there pulls from the right
        if (MyPos >= pos_i) begin
          char_d = right_i;
        end
      end
      default: char_d = char_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

  assign char_o = char_q;
  assign rd_o   = (Readable && (rd_idx_i == 8'(Idx))) ? char_q : 8'h00;

endmodule

### sv/kleb_read_group.sv
module kleb_read_group #(
  parameter int Size = kleb_pkg::GROUP_SIZE
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [Size-1:0][7:0] data_i,
  output logic [7:0]           or_o
);

  logic [7:0] or_q, or_d;

  // at most one input is nonzero: the cell whose index matches
  always_comb begin
    or_d = 8'h00;
    for (int i = 0; i < Size; i++) begin
      or_d = or_d | data_i[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      or_q <= or_d;
    end
  end

  assign or_o = or_q;

endmodule

### sv/keystroke_line_editor_buffer.sv
// Channel   Handshake                     Payload
// command   start in, busy out            in_i  (mode, key, read_index)
// result    out_valid_o strobe, 1 cycle   out_o (read_char, text_length, cursor_pos,
//                                                insert_on, overflow)
//
// Keystroke, clear and unused modes: the cell row shifts the whole
// text in the cycle the command transfers, and the result shows the next cycle.
// Read goes through the matching cell, registered group OR and final OR; busy holds until the final OR.
// Reset zeroes cursor and length and selects insert mode; cell contents are not reset.
// The result cannot be stalled; a new command may transfer while a result shows.
`include "assert_macros.svh"

module keystroke_line_editor_buffer #(
  parameter int BufferDepth = kleb_pkg::BUFFER_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  kleb_pkg::in_t in_i,
  output logic          out_valid_o,
  output kleb_pkg::out_t out_o
);

  localparam int PosW   = $clog2(BufferDepth + 1);
  localparam int Grp    = kleb_pkg::GROUP_SIZE;
  localparam int NGroup = (BufferDepth + Grp - 1) / Grp;
  localparam int CmpW   = (PosW > 8) ? PosW : 8;
  localparam logic [PosW-1:0] Full = PosW'(BufferDepth);

  logic [PosW-1:0] cursor_q, cursor_d;
  logic [PosW-1:0] length_q, length_d;
  logic            ins_q, ins_d;
  logic            rd_s1_q, rd_s2_q, rd_hit_q;
  logic [7:0]      rd_idx_q;
  logic            out_valid_q;
  kleb_pkg::out_t  out_q, out_d;

  logic                      accept;
  logic                      ovf;
  kleb_pkg::cell_ctl_t       ctl;
  logic [PosW-1:0]           cell_pos;
  logic [BufferDepth-1:0][7:0] chars;
  logic [NGroup*Grp-1:0][7:0]  rd_pad;
  logic [NGroup-1:0][7:0]      grp_or;
  logic [7:0]                  rd_all;

  assign busy   = rd_s1_q | rd_s2_q;
  assign accept = start & ~busy;

  always_comb begin
    cursor_d = cursor_q;
    length_d = length_q;
    ins_d    = ins_q;
    ovf      = 1'b0;
    ctl.op   = kleb_pkg::CELL_HOLD;
    ctl.ch   = in_i.key;
    cell_pos = cursor_q;
    if (accept) begin
      case (in_i.mode)
        kleb_pkg::MODE_KEY: begin
          case (in_i.key)
            kleb_pkg::KEY_INS:   ins_d = ~ins_q;
            kleb_pkg::KEY_HOME:  cursor_d = '0;
            kleb_pkg::KEY_END:   cursor_d = length_q;
            kleb_pkg::KEY_LEFT: begin
              if (cursor_q != '0) cursor_d = cursor_q - 1'b1;
            end
            kleb_pkg::KEY_RIGHT: begin
              if (cursor_q < length_q) cursor_d = cursor_q + 1'b1;
            end
            kleb_pkg::KEY_BKSP: begin
              if (cursor_q != '0) begin
                ctl.op   = kleb_pkg::CELL_DEL;
                cell_pos = cursor_q - 1'b1;
                cursor_d = cursor_q - 1'b1;
                length_d = length_q - 1'b1;
              end
            end
            kleb_pkg::KEY_NL: ;
            default: begin
              if (!ins_q && (cursor_q < length_q)) begin
                ctl.op   = kleb_pkg::CELL_OVR;
                cursor_d = cursor_q + 1'b1;
              end else if (length_q == Full) begin
                ovf = 1'b1;
              end else begin
                ctl.op   = kleb_pkg::CELL_INS;
                cursor_d = cursor_q + 1'b1;
                length_d = length_q + 1'b1;
              end
            end
          endcase
        end
        kleb_pkg::MODE_CLEAR: begin
          cursor_d = '0;
          length_d = '0;
        end
        default: ;
      endcase
    end
  end

  // cell row
  for (genvar i = 0; i < BufferDepth; i++) begin : g_cell
    logic [7:0] left_c, right_c;
    if (i == 0) begin : g_first
      assign left_c = 8'h00;
    end else begin : g_left
      assign left_c = chars[i-1];
    end
    if (i == BufferDepth - 1) begin : g_last
      assign right_c = 8'h00;
    end else begin : g_right
      assign right_c = chars[i+1];
    end
    kleb_cell #(
      .Idx  (i),
      .PosW (PosW)
    ) u_cell (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .pos_i    (cell_pos),
      .left_i   (left_c),
      .right_i  (right_c),
      .rd_idx_i (rd_idx_q),
      .char_o   (chars[i]),
      .rd_o     (rd_pad[i])
    );
  end

  for (genvar i = BufferDepth; i < NGroup * Grp; i++) begin : g_pad
    assign rd_pad[i] = 8'h00;
  end

  for (genvar g = 0; g < NGroup; g++) begin : g_grp
    kleb_read_group #(
      .Size (Grp)
    ) u_grp (
      .clk_i  (clk_i),
      .en_i   (rd_s1_q),
      .data_i (rd_pad[g*Grp +: Grp]),
      .or_o   (grp_or[g])
    );
  end

  always_comb begin
    rd_all = 8'h00;
    for (int g = 0; g < NGroup; g++) begin
      rd_all = rd_all | grp_or[g];
    end
  end

  always_comb begin
    out_d.read_char   = 8'h00;
    out_d.text_length = 9'(length_d);
    out_d.cursor_pos  = 9'(cursor_d);
    out_d.insert_on   = ins_d;
    out_d.overflow    = ovf;
    if (rd_s2_q) begin
      out_d.read_char = rd_hit_q ? rd_all : 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= '0;
      length_q    <= '0;
      ins_q       <= 1'b1;
      rd_s1_q     <= 1'b0;
      rd_s2_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cursor_q    <= cursor_d;
      length_q    <= length_d;
      ins_q       <= ins_d;
      rd_s1_q     <= accept && (in_i.mode == kleb_pkg::MODE_READ);
      rd_s2_q     <= rd_s1_q;
      out_valid_q <= (accept && (in_i.mode != kleb_pkg::MODE_READ)) || rd_s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept && (in_i.mode == kleb_pkg::MODE_READ)) begin
      rd_idx_q <= in_i.read_index;
      rd_hit_q <= CmpW'(in_i.read_index) < CmpW'(length_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `KLEB_NEVER(a_cursor_in_text, cursor_q > length_q)
  `KLEB_NEVER(a_length_in_range, length_q > Full)
  `KLEB_NEVER(a_read_stages_exclusive, rd_s1_q && rd_s2_q)
  `KLEB_ASSERT(a_read_completes, rd_s1_q |=> ##1 out_valid_q)
  `KLEB_ASSERT(a_cmd_result, (accept && in_i.mode != kleb_pkg::MODE_READ) |=> out_valid_q)
  `KLEB_ASSERT(a_overflow_when_full, (out_valid_q && out_q.overflow) |-> (length_q == Full))

endmodule
